/* src/dled_pkg.sv */
// ----------------------------------------------------------------------------
// DWARF location expression decoder package
// Phase codes, operand kinds and the opcode classification shared by the
// decoder modules.
// ----------------------------------------------------------------------------
package dled_pkg;

   localparam int unsigned AddrWidthReset   = 8;
   localparam int unsigned OffsetWidthReset = 4;
   localparam int unsigned MaxFixedBytes    = 8;
   localparam int unsigned LebMaxBytes      = 10;

   typedef enum logic [1:0] {
      CSR_ADDR_WIDTH   = 2'd0,
      CSR_OFFSET_WIDTH = 2'd1,
      CSR_BIG_ENDIAN   = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      PH_OPCODE        = 4'd0,
      PH_FIXED_U       = 4'd1,
      PH_FIXED_S       = 4'd2,
      PH_ULEB_A        = 4'd3,
      PH_SLEB_A        = 4'd4,
      PH_ULEB_A_SLEB_B = 4'd5,
      PH_ULEB_A_ULEB_B = 4'd6,
      PH_SLEB_B        = 4'd7,
      PH_ULEB_B        = 4'd8,
      PH_BLOCK_LEN     = 4'd9,
      PH_BLOCK_SKIP    = 4'd10
   } phase_type;

   typedef enum logic [3:0] {
      K_ERROR, K_DONE_ZERO, K_LIT, K_REG, K_BREG, K_ADDR, K_CALLREF,
      K_FIX1U, K_FIX1S, K_FIX2U, K_FIX2S, K_FIX4U, K_FIX4S, K_FIX8U, K_FIX8S,
      K_PHASE
   } op_kind_type;

   typedef struct packed {
      op_kind_type kind;
      phase_type   phase;
   } op_class_type;

   function automatic op_class_type classify(input logic [7:0] op);
      op_class_type c;
      c.kind  = K_ERROR;
      c.phase = PH_OPCODE;
      if (op >= 8'h30 && op <= 8'h4f) begin
         c.kind = K_LIT;
      end else if (op >= 8'h50 && op <= 8'h6f) begin
         c.kind = K_REG;
      end else if (op >= 8'h70 && op <= 8'h8f) begin
         c.kind = K_BREG;
      end else if (op == 8'h06 || op == 8'h12 || op == 8'h13 || op == 8'h14 ||
                   (op >= 8'h16 && op <= 8'h27 && op != 8'h23) ||
                   (op >= 8'h29 && op <= 8'h2e) || op == 8'h96 || op == 8'h97 ||
                   op == 8'h9b || op == 8'h9c || op == 8'h9f) begin
         c.kind = K_DONE_ZERO;
      end else begin
         case (op)
            8'h03: c.kind = K_ADDR;
            8'h9a: c.kind = K_CALLREF;
            8'h08, 8'h94, 8'h95, 8'h15: c.kind = K_FIX1U;
            8'h09: c.kind = K_FIX1S;
            8'h0a, 8'h98: c.kind = K_FIX2U;
            8'h0b, 8'h28, 8'h2f: c.kind = K_FIX2S;
            8'h0c, 8'h99: c.kind = K_FIX4U;
            8'h0d: c.kind = K_FIX4S;
            8'h0e: c.kind = K_FIX8U;
            8'h0f: c.kind = K_FIX8S;
            8'h10, 8'h23, 8'h90, 8'h93, 8'ha1, 8'ha2, 8'hfb: begin
               c.kind = K_PHASE; c.phase = PH_ULEB_A;
            end
            8'h11, 8'h91: begin c.kind = K_PHASE; c.phase = PH_SLEB_A; end
            8'h92: begin c.kind = K_PHASE; c.phase = PH_ULEB_A_SLEB_B; end
            8'h9d: begin c.kind = K_PHASE; c.phase = PH_ULEB_A_ULEB_B; end
            8'h9e, 8'ha3: begin c.kind = K_PHASE; c.phase = PH_BLOCK_LEN; end
            default: c.kind = K_ERROR;
         endcase
      end
      return c;
   endfunction

endpackage

/* src/dled_leb_step.sv */
// ----------------------------------------------------------------------------
// LEB128 byte step
// Folds one LEB128 byte into an accumulator, with overflow and length checks.
// ----------------------------------------------------------------------------
module dled_leb_step
   import dled_pkg::*;
(
   input  logic [63:0] acc,
   input  logic [7:0]  data,
   input  logic [6:0]  shift,
   input  logic [3:0]  count,
   input  logic        is_signed,
   output logic [63:0] acc_out,
   output logic [6:0]  shift_out,
   output logic [3:0]  count_out,
   output logic        finished,
   output logic        failed
);

   logic [63:0] payload;
   logic [63:0] merged;
   logic [6:0]  next_shift;

   always_comb begin
      payload    = {57'd0, data[6:0]};
      failed     = 1'b0;
      if (shift == 7'd63) begin
         if (is_signed) begin
            failed = (data[6:0] != 7'h00) && (data[6:0] != 7'h7f);
         end else begin
            failed = data[6:0] > 7'd1;
         end
      end
      merged = acc;
      if (shift < 7'd64) begin
         merged = acc | (payload << shift[5:0]);
      end
      next_shift = shift + 7'd7;
      finished   = 1'b0;
      acc_out    = merged;
      shift_out  = next_shift;
      count_out  = count + 4'd1;
      if (!failed) begin
         if (!data[7]) begin
            finished = 1'b1;
            if (is_signed && next_shift < 7'd64 && data[6]) begin
               acc_out = merged | ({64{1'b1}} << next_shift[5:0]);
            end
            shift_out = '0;
            count_out = '0;
         end else if (count_out >= 4'(LebMaxBytes)) begin
            failed = 1'b1;
         end
      end
   end

endmodule

/* src/dwarf_location_expression_decoder_top.sv */
// ----------------------------------------------------------------------------
// DWARF location expression decoder
// Decodes a location expression byte by byte into operations and operands.
// ----------------------------------------------------------------------------
// The decoder takes one expression byte per request and may accept a request
// in every cycle. Each accepted byte updates the registered parse state. A
// decoded operation or end-of-expression report is captured in an output
// register at the edge that accepts its closing byte, and it is offered on the
// response channel from the next cycle. The output register only stalls the
// input while a response is held and the consumer is not ready.
module dwarf_location_expression_decoder_top
   import dled_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   input  logic        req_empty_marker,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_op_valid,
   output logic [7:0]  rsp_op_code,
   output logic [63:0] rsp_first_operand,
   output logic [63:0] rsp_second_operand,
   output logic        rsp_expr_done,
   output logic        rsp_expr_complete,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [3:0]  csr_write_data
);

   logic [3:0]  addr_width_ff, offset_width_ff;
   logic        big_endian_ff;
   phase_type   phase_ff, phase_in;
   logic [7:0]  opcode_ff, opcode_in;
   logic [63:0] acc1_ff, acc1_in, acc2_ff, acc2_in;
   logic [6:0]  shift_ff, shift_in;
   logic [3:0]  count_ff, count_in;
   logic [3:0]  left_ff, left_in;
   logic [63:0] skip_ff, skip_in;
   logic        halted_ff, halted_in;

   logic        out_valid_ff, out_valid_in;
   logic        out_op_ff, out_op_in;
   logic [7:0]  out_code_ff, out_code_in;
   logic [63:0] out_a_ff, out_a_in, out_b_ff, out_b_in;
   logic        out_done_ff, out_done_in, out_cmpl_ff, out_cmpl_in;

   logic        accept;
   op_class_type cls;

   logic        leb_sel_two, leb_signed;
   logic [63:0] leb_acc, leb_acc_out;
   logic [6:0]  leb_shift_out;
   logic [3:0]  leb_count_out;
   logic        leb_fin, leb_fail;

   assign req_ready = !out_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign cls       = classify(req_data_byte);

   assign leb_sel_two = (phase_ff == PH_SLEB_B) || (phase_ff == PH_ULEB_B);
   assign leb_signed  = (phase_ff == PH_SLEB_A) || (phase_ff == PH_SLEB_B);
   assign leb_acc     = leb_sel_two ? acc2_ff : acc1_ff;

   dled_leb_step u_leb (
      .acc       (leb_acc),
      .data      (req_data_byte),
      .shift     (shift_ff),
      .count     (count_ff),
      .is_signed (leb_signed),
      .acc_out   (leb_acc_out),
      .shift_out (leb_shift_out),
      .count_out (leb_count_out),
      .finished  (leb_fin),
      .failed    (leb_fail)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_width_ff   <= 4'(AddrWidthReset);
         offset_width_ff <= 4'(OffsetWidthReset);
         big_endian_ff   <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_ADDR_WIDTH:   addr_width_ff   <= csr_write_data;
            CSR_OFFSET_WIDTH: offset_width_ff <= csr_write_data;
            CSR_BIG_ENDIAN:   big_endian_ff   <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      logic        have_op;
      logic        err;
      logic [3:0]  fw;
      logic        fs;
      logic [63:0] fixed_acc;
      logic [6:0]  fshift;
      phase_type   ph;

      phase_in  = phase_ff;
      opcode_in = opcode_ff;
      acc1_in   = acc1_ff;
      acc2_in   = acc2_ff;
      shift_in  = shift_ff;
      count_in  = count_ff;
      left_in   = left_ff;
      skip_in   = skip_ff;
      halted_in = halted_ff;
      have_op   = 1'b0;
      err       = 1'b0;
      fw        = '0;
      fs        = 1'b0;
      fixed_acc = '0;
      fshift    = '0;
      ph        = PH_OPCODE;

      if (!halted_ff) begin
         if (phase_ff == PH_OPCODE) begin
            opcode_in = req_data_byte;
            acc1_in   = '0;
            acc2_in   = '0;
            shift_in  = '0;
            count_in  = '0;
            left_in   = '0;
            skip_in   = '0;
            case (cls.kind)
               K_LIT: begin
                  acc1_in = {59'd0, 5'(req_data_byte - 8'h30)}; have_op = 1'b1;
               end
               K_REG: begin
                  acc1_in = {59'd0, 5'(req_data_byte - 8'h50)}; have_op = 1'b1;
               end
               K_BREG: begin
                  acc1_in = {59'd0, 5'(req_data_byte - 8'h70)}; phase_in = PH_SLEB_B;
               end
               K_DONE_ZERO: have_op = 1'b1;
               K_ADDR: begin
                  fw  = addr_width_ff;
                  err = (fw == 4'd0) || (fw > 4'(MaxFixedBytes));
               end
               K_CALLREF: begin
                  fw  = offset_width_ff;
                  err = (fw == 4'd0) || (fw > 4'(MaxFixedBytes));
               end
               K_FIX1U: fw = 4'd1;
               K_FIX1S: begin fw = 4'd1; fs = 1'b1; end
               K_FIX2U: fw = 4'd2;
               K_FIX2S: begin fw = 4'd2; fs = 1'b1; end
               K_FIX4U: fw = 4'd4;
               K_FIX4S: begin fw = 4'd4; fs = 1'b1; end
               K_FIX8U: fw = 4'd8;
               K_FIX8S: begin fw = 4'd8; fs = 1'b1; end
               K_PHASE: phase_in = cls.phase;
               default: err = 1'b1;
            endcase
            if (fw != 4'd0 && !err) begin
               left_in  = fw;
               phase_in = fs ? PH_FIXED_S : PH_FIXED_U;
            end
         end else begin
            case (phase_ff)
               PH_FIXED_U, PH_FIXED_S: begin
                  if (big_endian_ff) begin
                     fixed_acc = {acc1_ff[55:0], req_data_byte};
                  end else if (shift_ff < 7'd64) begin
                     fixed_acc = acc1_ff | ({56'd0, req_data_byte} << shift_ff[5:0]);
                  end else begin
                     fixed_acc = acc1_ff;
                  end
                  fshift   = shift_ff + 7'd8;
                  left_in  = (left_ff > 4'd0) ? left_ff - 4'd1 : left_ff;
                  acc1_in  = fixed_acc;
                  shift_in = fshift;
                  if (left_in == 4'd0) begin
                     if (phase_ff == PH_FIXED_S && fshift < 7'd64 &&
                         fixed_acc[6'(fshift - 7'd1)]) begin
                        acc1_in = fixed_acc | ({64{1'b1}} << fshift[5:0]);
                     end
                     shift_in = '0;
                     have_op  = 1'b1;
                  end
               end
               PH_ULEB_A, PH_SLEB_A, PH_SLEB_B, PH_ULEB_B,
               PH_ULEB_A_SLEB_B, PH_ULEB_A_ULEB_B, PH_BLOCK_LEN: begin
                  if (leb_fail) begin
                     err = 1'b1;
                  end else begin
                     if (leb_sel_two) acc2_in = leb_acc_out;
                     else             acc1_in = leb_acc_out;
                     shift_in = leb_shift_out;
                     count_in = leb_count_out;
                     if (leb_fin) begin
                        if (phase_ff == PH_ULEB_A_SLEB_B) begin
                           phase_in = PH_SLEB_B;
                        end else if (phase_ff == PH_ULEB_A_ULEB_B) begin
                           phase_in = PH_ULEB_B;
                        end else if (phase_ff == PH_BLOCK_LEN && leb_acc_out != 64'd0) begin
                           skip_in  = leb_acc_out;
                           phase_in = PH_BLOCK_SKIP;
                        end else begin
                           have_op = 1'b1;
                        end
                     end
                  end
               end
               PH_BLOCK_SKIP: begin
                  skip_in = (skip_ff != 64'd0) ? skip_ff - 64'd1 : skip_ff;
                  have_op = (skip_in == 64'd0);
               end
               default: err = 1'b1;
            endcase
         end
         if (err) halted_in = 1'b1;
         if (have_op) phase_in = PH_OPCODE;
      end
      ph = phase_in;

      out_op_in   = have_op;
      out_code_in = have_op ? opcode_in : 8'd0;
      out_a_in    = have_op ? acc1_in : 64'd0;
      out_b_in    = have_op ? acc2_in : 64'd0;
      out_done_in = req_last_byte;
      out_cmpl_in = req_last_byte && !halted_in && ph == PH_OPCODE;

      if (req_empty_marker) begin
         out_op_in   = 1'b0;
         out_code_in = '0;
         out_a_in    = '0;
         out_b_in    = '0;
         out_done_in = 1'b1;
         out_cmpl_in = 1'b1;
      end
      if (req_empty_marker || req_last_byte) begin
         phase_in  = PH_OPCODE;
         opcode_in = '0;
         acc1_in   = '0;
         acc2_in   = '0;
         shift_in  = '0;
         count_in  = '0;
         left_in   = '0;
         skip_in   = '0;
         halted_in = 1'b0;
      end
      out_valid_in = out_op_in || out_done_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_OPCODE;
         opcode_ff <= '0;
         acc1_ff   <= '0;
         acc2_ff   <= '0;
         shift_ff  <= '0;
         count_ff  <= '0;
         left_ff   <= '0;
         skip_ff   <= '0;
         halted_ff <= 1'b0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         opcode_ff <= opcode_in;
         acc1_ff   <= acc1_in;
         acc2_ff   <= acc2_in;
         shift_ff  <= shift_in;
         count_ff  <= count_in;
         left_ff   <= left_in;
         skip_ff   <= skip_in;
         halted_ff <= halted_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (accept) begin
         out_valid_ff <= out_valid_in;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         out_op_ff   <= out_op_in;
         out_code_ff <= out_code_in;
         out_a_ff    <= out_a_in;
         out_b_ff    <= out_b_in;
         out_done_ff <= out_done_in;
         out_cmpl_ff <= out_cmpl_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_op_valid       = out_op_ff;
   assign rsp_op_code        = out_code_ff;
   assign rsp_first_operand  = out_a_ff;
   assign rsp_second_operand = out_b_ff;
   assign rsp_expr_done      = out_done_ff;
   assign rsp_expr_complete  = out_cmpl_ff;

`ifndef NO_ASSERTIONS
   a_rsp_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_op_valid || rsp_expr_done))
      else $error("response carries neither operation nor done");
   a_cmpl_needs_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_expr_complete) |-> rsp_expr_done)
      else $error("complete without done");
   a_done_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_last_byte || req_empty_marker)) |=>
         (phase_ff == PH_OPCODE && !halted_ff))
      else $error("parse state not cleared at end of expression");
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_first_operand)))
      else $error("held response changed");
`endif

endmodule
